/* design/tofrg_pkg.sv */
`timescale 1ns / 1ps
// Package for the time-of-flight range result gate.
// Holds the shared constants, register indexes, result codes and the controller state type.
// Depends on nothing.
package tofrg_pkg;

    // Widths of the stream payloads.
    localparam int InDataWidth  = 104;
    localparam int OutDataWidth = 40;
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 32;

    // Width of the shared bit-serial divider.
    localparam int DivWidth = 32;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CfgDistanceMode = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CfgRangeMin     = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CfgRangeMax     = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CfgStaleLimit   = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CfgTargetRate   = 3'd4;

    // Configuration reset values.
    localparam logic [31:0] StaleLimitReset = 32'd1000000;
    localparam logic [15:0] TargetRateReset = 16'h0A00;

    // Result outcome codes.
    localparam logic [1:0] OutcomeFresh    = 2'd0;
    localparam logic [1:0] OutcomeRepeated = 2'd1;
    localparam logic [1:0] OutcomeStale    = 2'd2;
    localparam logic [1:0] OutcomeWaiting  = 2'd3;

    // Device status codes that carry a valid target.
    localparam logic [4:0] StatusAcceptA = 5'd4;
    localparam logic [4:0] StatusAcceptB = 5'd6;
    localparam logic [4:0] StatusAcceptC = 5'd8;
    localparam logic [4:0] StatusAcceptD = 5'd9;

    // Range limits in millimetres.
    localparam logic [15:0] NativeMinMm = 16'd40;
    localparam logic [15:0] ShortMaxMm  = 16'd1300;
    localparam logic [15:0] LongMaxMm   = 16'd4000;

    // Gain correction of 2011/2048 with rounding.
    localparam int          ProdWidth = 27;
    localparam logic [10:0] GainNum   = 11'd2011;
    localparam logic [10:0] GainHalf  = 11'h400;
    localparam int          GainShift = 11;

    localparam logic [15:0] SelectDefault = 16'h8000;
    localparam logic [15:0] Sat16         = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV1,
        S_DIV2,
        S_CLAMP,
        S_EMIT
    } state_t;

    // Handshake between the controller and the divider.
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic busy;
    } div_stat_t;

endpackage

/* design/tofrg_serial_div.sv */
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per clock.
// Depends on tofrg_pkg for the request and status structs.
module tofrg_serial_div #(
    parameter int WIDTH = tofrg_pkg::DivWidth
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tofrg_pkg::div_req_t   req,
    input  logic [WIDTH-1:0]      dividend,
    input  logic [WIDTH-1:0]      divisor,
    output tofrg_pkg::div_stat_t  stat,
    output logic [WIDTH-1:0]      quotient
);
    import tofrg_pkg::*;

    localparam int CntWidth = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CntWidth-1:0] LastCount = CntWidth'(WIDTH - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CntWidth-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0]    dvd_reg, dvd_next;
    logic [WIDTH-1:0]    rem_reg, rem_next;
    logic [WIDTH-1:0]    dsr_reg, dsr_next;

    logic [WIDTH:0] rem_shift;
    logic [WIDTH:0] diff;
    logic           fits;

    always_comb
    begin
        // The dividend register shifts out its top bit into the remainder and
        // takes the new quotient bit in at the bottom.
        rem_shift = {rem_reg, dvd_reg[WIDTH-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        fits      = rem_shift >= {1'b0, dsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
            dvd_next = {dvd_reg[WIDTH-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LastCount)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.done = done_reg;
    assign stat.busy = busy_reg;
    assign quotient  = dvd_reg;

endmodule

/* design/tof_range_result_gate.sv */
`timescale 1ns / 1ps
// Top level of the time-of-flight range result gate: controller, state and output register.
// Depends on tofrg_pkg and tofrg_serial_div.
//
// The block takes one poll item at a time and returns one result item for it. A poll
// without new data passes from S_PREP straight to S_EMIT and into the output register,
// after which the block returns to S_IDLE to accept the next item. A fresh reading
// passes through S_PREP, S_DIV1, S_DIV2, S_CLAMP and S_EMIT: one shared bit-serial
// divider produces one quotient bit per clock and runs twice, first for the scaled
// total rate over the SPAD count and then for the target rate over that per-SPAD rate;
// a zero SPAD count skips both divisions and a zero total skips the second.
// The next item is accepted as soon as the previous result has moved into the output
// register, even while it waits there.
module tof_range_result_gate (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input items.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // From bit 0: timestamp_us[31:0], range_status_byte[39:32], effective_spads[55:40],
    // ambient_rate[71:56], peak_signal_rate[87:72], final_range_mm[103:88].
    input  logic [tofrg_pkg::InDataWidth-1:0]      s_tdata,
    // From bit 0: data_not_ready.
    input  logic                                   s_tuser,
    // Result items.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // From bit 0: distance_mm[15:0], target_accepted[16], spads_select[32:17],
    // spads_update[33], device_status[38:34], zero[39].
    output logic [tofrg_pkg::OutDataWidth-1:0]     m_tdata,
    // From bit 0: outcome[1:0].
    output logic [1:0]                             m_tuser,
    // Configuration writes.
    input  logic                                   cfg_we,
    input  logic [tofrg_pkg::CfgIdxWidth-1:0]      cfg_index,
    input  logic [tofrg_pkg::CfgDataWidth-1:0]     cfg_data
);
    import tofrg_pkg::*;

    // Configuration registers.
    logic        mode_reg;
    logic [15:0] range_min_reg;
    logic [15:0] range_max_reg;
    logic [31:0] stale_limit_reg;
    logic [15:0] target_rate_reg;

    // Block state.
    logic [15:0] held_dist_reg, held_dist_next;
    logic        holds_reg, holds_next;
    logic [31:0] fresh_time_reg, fresh_time_next;

    state_t state_reg, state_next;

    // Captured item.
    logic        nr_reg, nr_next;
    logic [31:0] now_reg, now_next;
    logic [4:0]  status_reg, status_next;
    logic [15:0] spads_reg, spads_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] final_reg, final_next;
    logic [ProdWidth-1:0] prod_reg, prod_next;
    logic [15:0] sel_reg, sel_next;

    // Pending result.
    logic [1:0]  res_outcome_reg, res_outcome_next;
    logic [15:0] res_dist_reg, res_dist_next;
    logic        res_acc_reg, res_acc_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  out_outcome_reg, out_outcome_next;
    logic [15:0] out_dist_reg, out_dist_next;
    logic        out_acc_reg, out_acc_next;
    logic [15:0] out_sel_reg, out_sel_next;
    logic        out_upd_reg, out_upd_next;
    logic [4:0]  out_status_reg, out_status_next;

    div_req_t            div_req;
    div_stat_t           div_stat;
    logic [DivWidth-1:0] div_dividend;
    logic [DivWidth-1:0] div_divisor;
    logic [DivWidth-1:0] div_quotient;

    logic [16:0] rate_sum;
    logic [31:0] elapsed;
    logic        accepted;
    logic [15:0] lo_mm;
    logic [15:0] hi_mm;
    logic [15:0] dist_a;
    logic [15:0] dist_b;
    logic [15:0] dist_c;

    tofrg_serial_div #(
        .WIDTH (DivWidth)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    always_comb
    begin
        rate_sum = {1'b0, s_tdata[87:72]} + {1'b0, s_tdata[71:56]};
        elapsed  = now_reg - fresh_time_reg;
        accepted = (status_reg == StatusAcceptA) || (status_reg == StatusAcceptB) ||
                   (status_reg == StatusAcceptC) || (status_reg == StatusAcceptD);
        lo_mm    = (range_min_reg != 16'd0) ? range_min_reg : NativeMinMm;
        hi_mm    = (range_max_reg != 16'd0) ? range_max_reg
                                            : (mode_reg ? LongMaxMm : ShortMaxMm);
        // Rejected statuses report the maximum; the minimum clamp goes first so
        // that crossed limits end at the maximum.
        dist_a   = accepted ? prod_reg[ProdWidth-1:GainShift] : hi_mm;
        dist_b   = (dist_a < lo_mm) ? lo_mm : dist_a;
        dist_c   = (dist_b > hi_mm) ? hi_mm : dist_b;
    end

    always_comb
    begin
        state_next       = state_reg;
        held_dist_next   = held_dist_reg;
        holds_next       = holds_reg;
        fresh_time_next  = fresh_time_reg;
        nr_next          = nr_reg;
        now_next         = now_reg;
        status_next      = status_reg;
        spads_next       = spads_reg;
        total_next       = total_reg;
        final_next       = final_reg;
        prod_next        = prod_reg;
        sel_next         = sel_reg;
        res_outcome_next = res_outcome_reg;
        res_dist_next    = res_dist_reg;
        res_acc_next     = res_acc_reg;
        m_valid_next     = m_valid_reg & ~m_tready;
        out_outcome_next = out_outcome_reg;
        out_dist_next    = out_dist_reg;
        out_acc_next     = out_acc_reg;
        out_sel_next     = out_sel_reg;
        out_upd_next     = out_upd_reg;
        out_status_next  = out_status_reg;
        div_req.start    = 1'b0;
        div_dividend     = {total_reg, 16'h0000};
        div_divisor      = {16'h0000, spads_reg};
        s_tready         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    nr_next     = s_tuser;
                    now_next    = s_tdata[31:0];
                    status_next = s_tdata[36:32];
                    spads_next  = s_tdata[55:40];
                    total_next  = rate_sum[16] ? Sat16 : rate_sum[15:0];
                    final_next  = s_tdata[103:88];
                    state_next  = S_PREP;
                end
            end

            S_PREP:
            begin
                res_dist_next = 16'd0;
                res_acc_next  = 1'b0;
                sel_next      = 16'd0;
                if (nr_reg)
                begin
                    if (!holds_reg)
                    begin
                        res_outcome_next = OutcomeWaiting;
                    end
                    else if (elapsed > stale_limit_reg)
                    begin
                        holds_next       = 1'b0;
                        res_outcome_next = OutcomeStale;
                    end
                    else
                    begin
                        res_outcome_next = OutcomeRepeated;
                        res_dist_next    = held_dist_reg;
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    prod_next = ProdWidth'(final_reg) * ProdWidth'(GainNum) +
                                ProdWidth'(GainHalf);
                    fresh_time_next  = now_reg;
                    holds_next       = 1'b1;
                    res_outcome_next = OutcomeFresh;
                    if (spads_reg == 16'd0)
                    begin
                        sel_next   = SelectDefault;
                        state_next = S_CLAMP;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV1;
                    end
                end
            end

            S_DIV1:
            begin
                if (div_stat.done)
                begin
                    if (div_quotient == '0)
                    begin
                        sel_next   = SelectDefault;
                        state_next = S_CLAMP;
                    end
                    else
                    begin
                        div_dividend  = {target_rate_reg, 16'h0000};
                        div_divisor   = div_quotient;
                        div_req.start = 1'b1;
                        state_next    = S_DIV2;
                    end
                end
            end

            S_DIV2:
            begin
                if (div_stat.done)
                begin
                    sel_next   = (div_quotient[31:16] != 16'd0) ? Sat16 : div_quotient[15:0];
                    state_next = S_CLAMP;
                end
            end

            S_CLAMP:
            begin
                held_dist_next = dist_c;
                res_dist_next  = dist_c;
                res_acc_next   = accepted;
                state_next     = S_EMIT;
            end

            S_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next     = 1'b1;
                    out_outcome_next = res_outcome_reg;
                    out_dist_next    = res_dist_reg;
                    out_acc_next     = res_acc_reg;
                    out_sel_next     = sel_reg;
                    out_upd_next     = (res_outcome_reg == OutcomeFresh);
                    out_status_next  = (res_outcome_reg == OutcomeFresh) ? status_reg : 5'd0;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_dist_reg  <= 16'd0;
            holds_reg      <= 1'b0;
            fresh_time_reg <= 32'd0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            held_dist_reg  <= held_dist_next;
            holds_reg      <= holds_next;
            fresh_time_reg <= fresh_time_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            range_min_reg   <= 16'd0;
            range_max_reg   <= 16'd0;
            stale_limit_reg <= StaleLimitReset;
            target_rate_reg <= TargetRateReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgDistanceMode: mode_reg        <= cfg_data[0];
                CfgRangeMin:     range_min_reg   <= cfg_data[15:0];
                CfgRangeMax:     range_max_reg   <= cfg_data[15:0];
                CfgStaleLimit:   stale_limit_reg <= cfg_data;
                CfgTargetRate:   target_rate_reg <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        nr_reg          <= nr_next;
        now_reg         <= now_next;
        status_reg      <= status_next;
        spads_reg       <= spads_next;
        total_reg       <= total_next;
        final_reg       <= final_next;
        prod_reg        <= prod_next;
        sel_reg         <= sel_next;
        res_outcome_reg <= res_outcome_next;
        res_dist_reg    <= res_dist_next;
        res_acc_reg     <= res_acc_next;
        out_outcome_reg <= out_outcome_next;
        out_dist_reg    <= out_dist_next;
        out_acc_reg     <= out_acc_next;
        out_sel_reg     <= out_sel_next;
        out_upd_reg     <= out_upd_next;
        out_status_reg  <= out_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_outcome_reg;
    assign m_tdata  = {1'b0, out_status_reg, out_upd_reg, out_sel_reg, out_acc_reg, out_dist_reg};

endmodule
